// File: hw/rtl/pdf_text_to_utf8_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the PDF text to UTF-8 core.
// Each macro expands to one labelled concurrent assertion, clocked on the
// rising edge and disabled while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef PDF_TEXT_TO_UTF8_CORE_ASSERT_SVH
`define PDF_TEXT_TO_UTF8_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDFU8_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdfu8: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PDFU8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdfu8: next-cycle check failed");

`endif

// File: hw/rtl/pdfu8_pkg.sv
// ---------------------------------------------------------------------------
// pdfu8_pkg
// Shared types, constants and the UTF-8 encoder function of the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdfu8_pkg;

	localparam int MaxResults = 6;
	localparam int SeqBytes   = 4;

	localparam logic [7:0]  BomHigh  = 8'hFE;
	localparam logic [7:0]  BomLow   = 8'hFF;
	localparam logic [5:0]  HighSurrTag = 6'b110110;
	localparam logic [5:0]  LowSurrTag  = 6'b110111;
	localparam logic [20:0] SuppBase = 21'h10000;

	// Where the decoder stands within the string.
	typedef enum logic [2:0] {
		ST_START = 3'b001,
		ST_HELD  = 3'b010,
		ST_BODY  = 3'b100
	} pos_t;

	// One encoded code point: up to four bytes and their count.
	typedef struct packed {
		logic [SeqBytes-1:0][7:0] b;
		logic [2:0]               n;
	} u8seq_t;

	// All the results that one input item causes.
	typedef struct packed {
		logic [MaxResults-1:0][7:0] bytes;
		logic [2:0]                 cnt;
		logic                       empty;
		logic                       last;
	} grp_t;

	function automatic u8seq_t encode_cp(input logic [20:0] cp);
		u8seq_t s;
		s = '0;
		if (cp < 21'h80) begin
			s.b[0] = cp[7:0];
			s.n    = 3'd1;
		end else if (cp < 21'h800) begin
			s.b[0] = 8'hC0 | {3'b000, cp[10:6]};
			s.b[1] = 8'h80 | {2'b00, cp[5:0]};
			s.n    = 3'd2;
		end else if (cp < 21'h10000) begin
			s.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
			s.b[1] = 8'h80 | {2'b00, cp[11:6]};
			s.b[2] = 8'h80 | {2'b00, cp[5:0]};
			s.n    = 3'd3;
		end else begin
			s.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
			s.b[1] = 8'h80 | {2'b00, cp[17:12]};
			s.b[2] = 8'h80 | {2'b00, cp[11:6]};
			s.b[3] = 8'h80 | {2'b00, cp[5:0]};
			s.n    = 3'd4;
		end
		return s;
	endfunction

endpackage

// File: hw/rtl/pdfu8_decode.sv
// ---------------------------------------------------------------------------
// pdfu8_decode
// String state and the decode of one item into a group of UTF-8 bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdfu8_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       byte_s1,
	input  logic             last_s1,
	input  logic             take,
	output pdfu8_pkg::grp_t  grp,
	output logic             has_out
);

	pdfu8_pkg::pos_t st_q, st_d;
	logic       wide_q, wide_d;
	logic [7:0] hi_q, hi_d;
	logic       half_q, half_d;
	logic [9:0] pend_q, pend_d;
	logic       wait_q, wait_d;

	pdfu8_pkg::u8seq_t seq_a, seq_b, seq_flush;
	logic [15:0] unit;
	logic        unit_hi, unit_lo;
	logic [2:0]  total;
	logic [2:0]  boff;

	assign unit    = {hi_q, byte_s1};
	assign unit_hi = (unit[15:10] == pdfu8_pkg::HighSurrTag);
	assign unit_lo = (unit[15:10] == pdfu8_pkg::LowSurrTag);

	always_comb begin
		st_d   = st_q;
		wide_d = wide_q;
		hi_d   = hi_q;
		half_d = half_q;
		pend_d = pend_q;
		wait_d = wait_q;
		seq_a  = '0;
		seq_b  = '0;
		case (st_q)
			pdfu8_pkg::ST_START: begin
				if (byte_s1 == pdfu8_pkg::BomHigh && !last_s1) begin
					st_d = pdfu8_pkg::ST_HELD;
				end else begin
					st_d   = pdfu8_pkg::ST_BODY;
					wide_d = 1'b0;
					seq_a  = pdfu8_pkg::encode_cp({13'd0, byte_s1});
				end
			end
			pdfu8_pkg::ST_HELD: begin
				st_d = pdfu8_pkg::ST_BODY;
				if (byte_s1 == pdfu8_pkg::BomLow) begin
					wide_d = 1'b1;
				end else begin
					wide_d = 1'b0;
					seq_a  = pdfu8_pkg::encode_cp({13'd0, pdfu8_pkg::BomHigh});
					seq_b  = pdfu8_pkg::encode_cp({13'd0, byte_s1});
				end
			end
			default: begin
				if (!wide_q) begin
					seq_a = pdfu8_pkg::encode_cp({13'd0, byte_s1});
				end else if (!half_q) begin
					hi_d   = byte_s1;
					half_d = 1'b1;
				end else begin
					half_d = 1'b0;
					if (wait_q && unit_lo) begin
						wait_d = 1'b0;
						pend_d = '0;
						seq_a  = pdfu8_pkg::encode_cp(pdfu8_pkg::SuppBase +
							21'({pend_q, unit[9:0]}));
					end else begin
						if (wait_q) begin
							seq_a  = pdfu8_pkg::encode_cp({5'd0, pdfu8_pkg::HighSurrTag,
								pend_q});
							wait_d = 1'b0;
							pend_d = '0;
						end
						if (unit_hi) begin
							pend_d = unit[9:0];
							wait_d = 1'b1;
						end else if (wait_q) begin
							seq_b = pdfu8_pkg::encode_cp({5'd0, unit});
						end else begin
							seq_a = pdfu8_pkg::encode_cp({5'd0, unit});
						end
					end
				end
			end
		endcase

		// At the end of the string a high surrogate still held goes out alone.
		seq_flush = pdfu8_pkg::encode_cp({5'd0, pdfu8_pkg::HighSurrTag, pend_d});
		if (last_s1 && wide_d && wait_d) begin
			if (seq_a.n == 3'd0) begin
				seq_a = seq_flush;
			end else begin
				seq_b = seq_flush;
			end
		end
	end

	assign total = seq_a.n + seq_b.n;

	always_comb begin
		grp       = '0;
		grp.last  = last_s1;
		grp.empty = (total == 3'd0);
		grp.cnt   = (total == 3'd0) ? 3'd1 : total;
		boff      = '0;
		for (int i = 0; i < pdfu8_pkg::MaxResults; i++) begin
			boff = 3'(i) - seq_a.n;
			if (3'(i) < seq_a.n) begin
				grp.bytes[i] = seq_a.b[i[1:0]];
			end else if (3'(i) < total) begin
				grp.bytes[i] = seq_b.b[boff[1:0]];
			end
		end
	end

	assign has_out = (total != 3'd0) || last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= pdfu8_pkg::ST_START;
			wide_q <= 1'b0;
			hi_q   <= '0;
			half_q <= 1'b0;
			pend_q <= '0;
			wait_q <= 1'b0;
		end else if (take) begin
			if (last_s1) begin
				st_q   <= pdfu8_pkg::ST_START;
				wide_q <= 1'b0;
				hi_q   <= '0;
				half_q <= 1'b0;
				pend_q <= '0;
				wait_q <= 1'b0;
			end else begin
				st_q   <= st_d;
				wide_q <= wide_d;
				hi_q   <= hi_d;
				half_q <= half_d;
				pend_q <= pend_d;
				wait_q <= wait_d;
			end
		end
	end

endmodule

// File: hw/rtl/pdfu8_emit.sv
// ---------------------------------------------------------------------------
// pdfu8_emit
// Result register: one group of bytes, sent one byte a cycle unless stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pdf_text_to_utf8_core_assert.svh"

module pdfu8_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  pdfu8_pkg::grp_t  grp_in,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             out_last
);

	pdfu8_pkg::grp_t grp_q;
	logic       valid_q;
	logic [2:0] idx_q;
	logic       at_end;
	logic       fire;

	assign at_end = (idx_q == grp_q.cnt - 3'd1);
	assign fire   = valid_q && out_ready;
	assign free   = !valid_q || (out_ready && at_end);

	assign out_valid  = valid_q;
	assign out_byte   = grp_q.bytes[idx_q];
	assign byte_valid = !grp_q.empty;
	assign out_last   = grp_q.last && at_end;

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= grp_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (fire) begin
			if (at_end) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	`PDFU8_ASSERT_IMPLY(a_cnt_range, clk, arst_n, valid_q, grp_q.cnt != 3'd0 && grp_q.cnt <= 3'(pdfu8_pkg::MaxResults))
	`PDFU8_ASSERT_IMPLY(a_idx_range, clk, arst_n, valid_q, idx_q < grp_q.cnt)
	`PDFU8_ASSERT_IMPLY(a_empty_is_end, clk, arst_n, valid_q && grp_q.empty, grp_q.cnt == 3'd1 && grp_q.last)
	`PDFU8_ASSERT_NEXT(a_load_starts, clk, arst_n, load, valid_q && idx_q == 3'd0)

endmodule

// File: hw/rtl/pdf_text_to_utf8_core.sv
// ---------------------------------------------------------------------------
// pdf_text_to_utf8_core
// Converts a PDF text string, one byte per item, into UTF-8 bytes.
// ---------------------------------------------------------------------------
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+------------------------------
//   in      | into core | in_valid, in_ready  | in_byte, in_last
//   out     | from core | out_valid, out_ready| out_byte, byte_valid, out_last
//
// Each output byte takes one handshake on the out channel, so an input item
// occupies the core for as many handshakes as it yields results: one or two
// for Latin-1 text (up to four after a leading FE byte), up to six in
// UTF-16BE text. Non-last items that yield nothing skip the out channel.
// Reset (arst_n low) empties both registers and returns to the string start.
// A stall on the out channel holds the current byte; one further item waits
// in the input register and is decoded as soon as the result register frees.
//
`timescale 1ns / 1ps

module pdf_text_to_utf8_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       out_last
);

	// Input register: the item being decoded.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	pdfu8_pkg::grp_t grp;
	logic has_out;
	logic free;
	logic take;
	logic load;

	// The held item leaves the input register when it yields no result, or
	// when the result register is empty or sends its final byte this cycle.
	assign take     = valid_s1 && (!has_out || free);
	assign load     = take && has_out;
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Decode of the held item against the string state.
	pdfu8_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.take    (take),
		.grp     (grp),
		.has_out (has_out)
	);

	// Result register and byte sequencer.
	pdfu8_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.grp_in     (grp),
		.free       (free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.out_last   (out_last)
	);

endmodule
